FILE: hdl/b2da_pkg.sv
// Shared constants and types for the binary to decimal ASCII emitter.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_BITS = 32;
    // Decimal digits of the largest value: floor(bits * log10(2)) + 1
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(DIGITS + 1);
    localparam int CHAR_W     = 7;
    localparam int TDATA_IN_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [BCD_W-1:0]      bcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT,
        ST_NL
    } back_state_t;

    // Handshake between value queue and conversion back end
    typedef struct packed {
        logic   valid;
        value_t data;
    } queue_out_t;

endpackage

FILE: hdl/b2da_queue.sv
// Two-entry value queue between the input port and the converter.
`timescale 1ns / 1ps

module b2da_queue
    import b2da_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  value_t     push_data,
    output logic       full,
    input  logic       pop,
    output queue_out_t head
);

    value_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/b2da_back.sv
// Double dabble converter and character emitter with output register.
`timescale 1ns / 1ps

module b2da_back
    import b2da_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  queue_out_t             head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    back_state_t           state_reg;
    back_state_t           state_next;
    value_t                value_reg;
    value_t                value_next;
    bcd_t                  bcd_reg;
    bcd_t                  bcd_next;
    bcd_t                  bcd_adj;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg;
    logic [DIG_CNT_W-1:0]  dig_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg;
    logic [CHAR_W-1:0]     out_char_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  slot_free;
    logic [3:0]            top_digit;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_char_reg};
    assign m_tlast   = out_last_reg;
    assign slot_free = !out_valid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop          = 1'b1;
                    value_next   = head.data;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], value_reg[VALUE_BITS-1]};
                value_next   = {value_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    dig_cnt_next = DIG_CNT_W'(DIGITS);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the units digit
                if (top_digit == 4'd0 && dig_cnt_reg > DIG_CNT_W'(1))
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {3'b000, top_digit};
                    out_last_next  = 1'b0;
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next   = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_NL;
                    end
                end
            end
            ST_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NEWLINE;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: hdl/binary_to_decimal_ascii_emitter_unit.sv
// Top level: value queue feeding the decimal converter and emitter.
//
// Each 32-bit word on the input is printed as decimal ASCII digits, most
// significant first with leading zeros dropped, then a newline that carries
// tlast. A value is loaded, converted by one double dabble shift per input
// bit, stripped of leading zeros one digit at a time, and then emitted one
// character at a time (digits plus newline). Skipped zeros and digits always
// add up to ten; the single shared shift-add-3 converter works on one value
// at a time. A two-word queue keeps the input open while a value is being
// converted.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_emitter_unit
    import b2da_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // [31:0] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,  // [6:0] ascii_char, [7] zero
    output logic                   m_tlast
);

    queue_out_t head;
    logic       pop;
    logic       full;
    logic       first_reg;
    logic       zero_lead_reg;

    assign s_tready = !full;

    b2da_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (s_tdata[VALUE_BITS-1:0]),
        .full      (full),
        .pop       (pop),
        .head      (head)
    );

    b2da_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // run tracking on the output side, used by the checks below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            zero_lead_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            first_reg     <= m_tlast;
            zero_lead_reg <= first_reg && !m_tlast && (m_tdata[CHAR_W-1:0] == CHAR_ZERO);
        end
    end

    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[CHAR_W-1:0] == CHAR_NEWLINE)
        else $error("closing word is not a newline");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |->
            m_tdata[CHAR_W-1:0] >= CHAR_ZERO && m_tdata[CHAR_W-1:0] <= CHAR_ZERO + 7'd9)
        else $error("digit word out of range");

    a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && first_reg |-> !m_tlast)
        else $error("run without digits");

    a_leading_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && zero_lead_reg |-> m_tlast)
        else $error("leading zero not suppressed");

endmodule

FILE: tb/tb_binary_to_decimal_ascii_emitter_unit.sv
// Testbench for the binary to decimal ASCII emitter: random and directed values, checked per character.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_emitter_unit;
    import b2da_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 115;
    localparam int TAIL_CYCLES = 80;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    typedef struct {
        logic [CHAR_W-1:0] ascii_char;
        logic              last;
    } char_word_t;

    class decimal_scoreboard;
        char_word_t pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // Expand one accepted value into its digit words and the closing newline.
        function void note_value(value_t v);
            logic [CHAR_W-1:0] digs[$];
            value_t            n;
            char_word_t        w;
            n = v;
            do
            begin
                digs.push_front(CHAR_ZERO + CHAR_W'(n % 10));
                n = n / 10;
            end
            while (n != 0);
            foreach (digs[i])
            begin
                w.ascii_char = digs[i];
                w.last       = 1'b0;
                pending_chars.push_back(w);
            end
            w.ascii_char = CHAR_NEWLINE;
            w.last       = 1'b1;
            pending_chars.push_back(w);
        endfunction

        function void check_char(logic [TDATA_OUT_W-1:0] data, logic last);
            char_word_t w;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected output word: data %0d last %0d", data, last);
                errors++;
                return;
            end
            w = pending_chars.pop_front();
            if (data[CHAR_W-1:0] !== w.ascii_char)
            begin
                $error("ascii_char: expected %0d, actual %0d", w.ascii_char, data[CHAR_W-1:0]);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last: expected %0d, actual %0d", w.last, last);
                errors++;
            end
            if (data[TDATA_OUT_W-1:CHAR_W] !== '0)
            begin
                $error("pad: expected 0, actual %0d", data[TDATA_OUT_W-1:CHAR_W]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    decimal_scoreboard digit_sb;

    binary_to_decimal_ascii_emitter_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            digit_sb.check_char(m_tdata, m_tlast);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("binary_to_decimal_ascii_emitter_unit test failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_value(input value_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'(v);
        do
            @(posedge clk);
        while (!s_tready);
        digit_sb.note_value(v);
        @(negedge clk);
    endtask

    // Mostly picks a decimal length first so that every digit count shows up.
    function automatic value_t rand_value();
        longint unsigned lo;
        longint unsigned hi;
        int              ndig;
        if ($urandom_range(0, 99) < 30)
            return value_t'($urandom);
        ndig = $urandom_range(1, 10);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        return value_t'(lo + (longint'($urandom) % (hi - lo + 1)));
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_value(rand_value());
    endtask

    initial
    begin
        value_t directed[$];
        digit_sb       = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero, digit-count boundaries, and the extremes of the 32-bit range
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000,
                     32'd999999999, 32'd1000000000, 32'd1234567890,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4000000000};
        foreach (directed[i])
            send_value(directed[i]);

        run_random(PHASE_ITEMS);
        send_idle_pct = 58;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        run_random(PHASE_ITEMS);

        // Long output hold-off while input keeps coming: the value queue fills
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        hold_left = 600;
        @(negedge clk);
        repeat (12) send_value(value_t'($urandom));

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_random(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (digit_sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (digit_sb.errors == 0)
            $display("binary_to_decimal_ascii_emitter_unit test passed");
        else
            $display("binary_to_decimal_ascii_emitter_unit test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/b2da_pkg.sv
hdl/b2da_queue.sv
hdl/b2da_back.sv
hdl/binary_to_decimal_ascii_emitter_unit.sv
tb/tb_binary_to_decimal_ascii_emitter_unit.sv
